FILE: rtl/gftm_pkg.sv
// Package for the grouped fault timeout monitor.
// Holds sizes, command, event and register codes, and the item and configuration types.
// No dependencies.
package gftm_pkg;

   localparam int NUM_GROUPS          = 4;
   localparam int INSTANCES_PER_GROUP = 4;
   localparam int DELAY_WIDTH         = 16;
   localparam int DELAY_REGS          = 4;
   localparam int SLOT_COUNT          = NUM_GROUPS * INSTANCES_PER_GROUP;
   localparam int SLOT_W              = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int DREG_W              = $clog2(DELAY_REGS);
   localparam int LIM_W               = 4;
   localparam int CMD_W               = 2;
   localparam int GRP_W               = 3;
   localparam int INST_W              = 3;
   localparam int EV_W                = 2;
   localparam int COUNT_W             = 5;
   localparam int CFG_DATA_W          = 16;
   localparam int CFG_IDX_W           = 3;
   localparam int LIMREG_W            = 3;
   localparam int REQ_DATA_W          = 8;
   localparam int RSP_DATA_W          = 16;

   localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_RAISE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

   localparam logic [EV_W-1:0] EV_NONE    = 2'd0;
   localparam logic [EV_W-1:0] EV_RAISED  = 2'd1;
   localparam logic [EV_W-1:0] EV_CLEARED = 2'd2;
   localparam logic [EV_W-1:0] EV_EXPIRED = 2'd3;

   localparam logic ST_OK    = 1'b0;
   localparam logic ST_RANGE = 1'b1;

   localparam logic [CFG_IDX_W-1:0] REG_DELAY0    = 3'd0;
   localparam logic [CFG_IDX_W-1:0] REG_DELAY1    = 3'd1;
   localparam logic [CFG_IDX_W-1:0] REG_DELAY2    = 3'd2;
   localparam logic [CFG_IDX_W-1:0] REG_DELAY3    = 3'd3;
   localparam logic [CFG_IDX_W-1:0] REG_GROUPS    = 3'd4;
   localparam logic [CFG_IDX_W-1:0] REG_INSTANCES = 3'd5;

   localparam logic [CFG_DATA_W-1:0] DELAY_RESET = 16'd1000;
   localparam logic [LIMREG_W-1:0]   LIMIT_RESET = 3'd4;

   typedef struct packed {
      logic [INST_W-1:0] instance_req;
      logic [GRP_W-1:0]  group;
      logic [CMD_W-1:0]  command;
   } req_type;

   typedef struct packed {
      logic [1:0]         fill;
      logic [COUNT_W-1:0] armed_count;
      logic [INST_W-1:0]  slot_instance;
      logic [GRP_W-1:0]   slot_group;
      logic               status;
      logic [EV_W-1:0]    event_res;
   } rsp_type;

   typedef struct packed {
      logic [DELAY_REGS-1:0][CFG_DATA_W-1:0] delay;
      logic [LIMREG_W-1:0]                   groups_in_use;
      logic [LIMREG_W-1:0]                   instances_in_use;
   } cfg_type;

endpackage

FILE: rtl/gftm_countdown_unit.sv
// Shared countdown unit: loads a slot with its group delay or steps it down by one.
// Depends on gftm_pkg.
module gftm_countdown_unit import gftm_pkg::*; (
   input  logic                   load,
   input  logic [DELAY_WIDTH-1:0] load_value,
   input  logic [DELAY_WIDTH-1:0] cur_value,
   output logic [DELAY_WIDTH-1:0] next_value,
   output logic                   expired
);

   // A zero delay arms the slot with a single tick.
   assign next_value = load ? ((load_value == '0) ? DELAY_WIDTH'(1) : load_value)
                            : cur_value - DELAY_WIDTH'(1);
   assign expired    = (next_value == '0);

endmodule

FILE: rtl/gftm_sequencer.sv
// Sequencer of the fault timeout monitor: slot flags and countdowns, command handling,
// the slot walk on each tick and the result register. Depends on gftm_pkg and
// gftm_countdown_unit.
module gftm_sequencer import gftm_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  cfg_type               cfg,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  req_type               req_item,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output rsp_type               rsp_item,
   output logic                  rsp_tlast
);

   typedef enum logic [1:0] {S_IDLE, S_EXEC, S_WALK, S_FINISH} state_type;

   state_type          state_ff, state_in;
   logic [CMD_W-1:0]   cmd_ff, cmd_in;
   logic [GRP_W-1:0]   grp_ff, grp_in;
   logic [INST_W-1:0]  inst_ff, inst_in;
   logic [SLOT_W-1:0]  slot_ff, slot_in;
   logic [SLOT_COUNT-1:0] armed_ff, armed_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               pend_valid_ff, pend_valid_in;
   logic [SLOT_W-1:0]  pend_slot_ff, pend_slot_in;
   logic [COUNT_W-1:0] pend_count_ff, pend_count_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;
   logic               rsp_last_ff, rsp_last_in;

   logic [DELAY_WIDTH-1:0] ticks_ff [SLOT_COUNT];
   logic                   ticks_we;

   logic                   out_free;
   logic [LIM_W-1:0]       glim, ilim;
   logic                   range_bad;
   logic [SLOT_W-1:0]      req_slot, slot_sel;
   logic                   unit_load;
   logic [DELAY_WIDTH-1:0] unit_next;
   logic                   unit_expired;
   logic [GRP_W-1:0]       pend_grp;
   logic [INST_W-1:0]      pend_inst;

   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign glim      = (LIM_W'(cfg.groups_in_use) > LIM_W'(NUM_GROUPS))
                      ? LIM_W'(NUM_GROUPS) : LIM_W'(cfg.groups_in_use);
   assign ilim      = (LIM_W'(cfg.instances_in_use) > LIM_W'(INSTANCES_PER_GROUP))
                      ? LIM_W'(INSTANCES_PER_GROUP) : LIM_W'(cfg.instances_in_use);
   assign range_bad = (LIM_W'(grp_ff) >= glim) || (LIM_W'(inst_ff) >= ilim);
   assign req_slot  = SLOT_W'(SLOT_W'(grp_ff) * SLOT_W'(INSTANCES_PER_GROUP)
                      + SLOT_W'(inst_ff));
   assign unit_load = (state_ff == S_EXEC);
   assign slot_sel  = unit_load ? req_slot : slot_ff;
   assign pend_grp  = GRP_W'(pend_slot_ff / INSTANCES_PER_GROUP);
   assign pend_inst = INST_W'(pend_slot_ff % INSTANCES_PER_GROUP);

   gftm_countdown_unit u_unit (
      .load       (unit_load),
      .load_value (DELAY_WIDTH'(cfg.delay[grp_ff[DREG_W-1:0]])),
      .cur_value  (ticks_ff[slot_sel]),
      .next_value (unit_next),
      .expired    (unit_expired)
   );

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      grp_in        = grp_ff;
      inst_in       = inst_ff;
      slot_in       = slot_ff;
      armed_in      = armed_ff;
      count_in      = count_ff;
      pend_valid_in = pend_valid_ff;
      pend_slot_in  = pend_slot_ff;
      pend_count_in = pend_count_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      rsp_last_in   = rsp_last_ff;
      ticks_we      = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd_in   = req_item.command;
               grp_in   = req_item.group;
               inst_in  = req_item.instance_req;
               slot_in  = '0;
               state_in = (req_item.command == CMD_TICK) ? S_WALK : S_EXEC;
            end
         end
         S_EXEC: begin
            if (out_free) begin
               rsp_data_in               = '0;
               rsp_data_in.event_res     = EV_NONE;
               rsp_data_in.status        = ST_OK;
               rsp_data_in.slot_group    = grp_ff;
               rsp_data_in.slot_instance = inst_ff;
               if (range_bad) begin
                  rsp_data_in.status = ST_RANGE;
               end
               case (cmd_ff)
                  CMD_RAISE: begin
                     if (!range_bad && !armed_ff[req_slot]) begin
                        ticks_we              = 1'b1;
                        armed_in[req_slot]    = 1'b1;
                        count_in              = count_ff + COUNT_W'(1);
                        rsp_data_in.event_res = EV_RAISED;
                     end
                  end
                  CMD_CLEAR: begin
                     if (!range_bad && armed_ff[req_slot]) begin
                        armed_in[req_slot]    = 1'b0;
                        count_in              = count_ff - COUNT_W'(1);
                        rsp_data_in.event_res = EV_CLEARED;
                     end
                  end
                  default: begin
                     rsp_data_in               = '0;
                     rsp_data_in.event_res     = EV_NONE;
                     rsp_data_in.status        = ST_OK;
                  end
               endcase
               rsp_data_in.armed_count = count_in;
               rsp_valid_in            = 1'b1;
               rsp_last_in             = 1'b1;
               state_in                = S_IDLE;
            end
         end
         S_WALK: begin
            if (out_free) begin
               if (armed_ff[slot_ff]) begin
                  ticks_we = 1'b1;
                  if (unit_expired) begin
                     armed_in[slot_ff] = 1'b0;
                     count_in          = count_ff - COUNT_W'(1);
                     if (pend_valid_ff) begin
                        rsp_data_in               = '0;
                        rsp_data_in.event_res     = EV_EXPIRED;
                        rsp_data_in.status        = ST_OK;
                        rsp_data_in.slot_group    = pend_grp;
                        rsp_data_in.slot_instance = pend_inst;
                        rsp_data_in.armed_count   = pend_count_ff;
                        rsp_valid_in              = 1'b1;
                        rsp_last_in               = 1'b0;
                     end
                     pend_valid_in = 1'b1;
                     pend_slot_in  = slot_ff;
                     pend_count_in = count_in;
                  end
               end
               if (slot_ff == SLOT_W'(SLOT_COUNT - 1)) begin
                  state_in = S_FINISH;
               end else begin
                  slot_in = slot_ff + SLOT_W'(1);
               end
            end
         end
         S_FINISH: begin
            if (out_free) begin
               rsp_data_in        = '0;
               rsp_data_in.status = ST_OK;
               if (pend_valid_ff) begin
                  rsp_data_in.event_res     = EV_EXPIRED;
                  rsp_data_in.slot_group    = pend_grp;
                  rsp_data_in.slot_instance = pend_inst;
                  rsp_data_in.armed_count   = pend_count_ff;
               end else begin
                  rsp_data_in.event_res   = EV_NONE;
                  rsp_data_in.armed_count = count_ff;
               end
               rsp_valid_in  = 1'b1;
               rsp_last_in   = 1'b1;
               pend_valid_in = 1'b0;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         armed_ff      <= '0;
         count_ff      <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         armed_ff      <= armed_in;
         count_ff      <= count_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      cmd_ff        <= cmd_in;
      grp_ff        <= grp_in;
      inst_ff       <= inst_in;
      slot_ff       <= slot_in;
      pend_slot_ff  <= pend_slot_in;
      pend_count_ff <= pend_count_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_last_ff   <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (ticks_we) begin
         ticks_ff[slot_sel] <= unit_next;
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_item   = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

FILE: rtl/grouped_fault_timeout_monitor.sv
// Grouped fault timeout monitor. A raise or clear item has its result registered in the
// execute state, and the block is ready for a new item while that result is presented.
// A tick walks all 16 slots through the one countdown unit, one slot per cycle while the
// result side is not stalled, and its last result is registered in the finish state.
// Synchronous reset disarms every slot, zeroes the armed count and restores all delays to
// 1000 and both limits to 4; the countdown store is not cleared.
module grouped_fault_timeout_monitor import gftm_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // command, group, instance_req
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,  // event_res, status, slot_group,
                                             // slot_instance, armed_count, zero fill
   output logic                  rsp_tlast,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CFG_IDX_W-1:0]  csr_index,
   input  logic [CFG_DATA_W-1:0] csr_data
);

   cfg_type cfg_ff, cfg_in;
   rsp_type rsp_view;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            REG_DELAY0:    cfg_in.delay[0]         = csr_data;
            REG_DELAY1:    cfg_in.delay[1]         = csr_data;
            REG_DELAY2:    cfg_in.delay[2]         = csr_data;
            REG_DELAY3:    cfg_in.delay[3]         = csr_data;
            REG_GROUPS:    cfg_in.groups_in_use    = csr_data[LIMREG_W-1:0];
            REG_INSTANCES: cfg_in.instances_in_use = csr_data[LIMREG_W-1:0];
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.delay            <= {DELAY_REGS{DELAY_RESET}};
         cfg_ff.groups_in_use    <= LIMIT_RESET;
         cfg_ff.instances_in_use <= LIMIT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   gftm_sequencer u_seq (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_item   (req_type'(req_tdata)),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_item   (rsp_view),
      .rsp_tlast  (rsp_tlast)
   );

   assign rsp_tdata = rsp_view;

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("block ready right after taking an item");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_view.armed_count <= COUNT_W'(SLOT_COUNT)))
      else $error("armed count exceeds slot count");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_view.status == ST_RANGE)) |->
         ((rsp_view.event_res == EV_NONE) && rsp_tlast))
      else $error("range error result changed state or was not last");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tlast) |-> (rsp_view.event_res == EV_EXPIRED))
      else $error("non-final result that is not an expiry");
`endif

endmodule

FILE: verif/gftm_checker.sv
// Checker for the grouped fault timeout monitor: predicts every result of each accepted item
// from its own copy of the slot table and settings, and compares the results that come back.
// Depends on gftm_pkg for the sizes, codes and item layouts.
module gftm_checker import gftm_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  rsp_tlast,
   input  logic                  csr_valid,
   input  logic                  csr_ready,
   input  logic [CFG_IDX_W-1:0]  csr_index,
   input  logic [CFG_DATA_W-1:0] csr_data,
   output int                    failures,
   output int                    pending,
   output int                    results_seen,
   output int                    expiries_seen
);

   typedef struct packed {
      logic [EV_W-1:0]    ev;
      logic               st;
      logic [GRP_W-1:0]   grp;
      logic [INST_W-1:0]  inst;
      logic [COUNT_W-1:0] count;
      logic               last;
   } fault_report_type;

   fault_report_type       expected_events[$];
   logic [CFG_DATA_W-1:0]  delay_reg [DELAY_REGS];
   logic [LIMREG_W-1:0]    group_limit;
   logic [LIMREG_W-1:0]    inst_limit;
   logic [SLOT_COUNT-1:0]  armed;
   logic [DELAY_WIDTH-1:0] countdown [SLOT_COUNT];
   logic [COUNT_W-1:0]     armed_total;
   fault_report_type       want;
   rsp_type                got;

   initial begin
      failures      = 0;
      pending       = 0;
      results_seen  = 0;
      expiries_seen = 0;
   end

   function automatic fault_report_type report(input logic [EV_W-1:0] ev, input logic st,
                                               input logic [GRP_W-1:0] g,
                                               input logic [INST_W-1:0] i, input logic last);
      fault_report_type r;
      r.ev    = ev;
      r.st    = st;
      r.grp   = g;
      r.inst  = i;
      r.count = armed_total;
      r.last  = last;
      return r;
   endfunction

   task automatic apply_fault_command(input req_type item);
      fault_report_type       batch [SLOT_COUNT];
      int                     n;
      int                     glim;
      int                     ilim;
      int                     slot;
      logic [DELAY_WIDTH-1:0] d;
      n = 0;
      case (item.command)
         CMD_TICK: begin
            for (int s = 0; s < SLOT_COUNT; s++) begin
               if (armed[s]) begin
                  countdown[s] = countdown[s] - 1'b1;
                  if (countdown[s] == '0) begin
                     armed[s]    = 1'b0;
                     armed_total = armed_total - 1'b1;
                     batch[n]    = report(EV_EXPIRED, ST_OK,
                                          GRP_W'(s / INSTANCES_PER_GROUP),
                                          INST_W'(s % INSTANCES_PER_GROUP), 1'b0);
                     n++;
                  end
               end
            end
            if (n == 0) begin
               expected_events.push_back(report(EV_NONE, ST_OK, '0, '0, 1'b1));
            end
            for (int k = 0; k < n; k++) begin
               batch[k].last = (k == n - 1);
               expected_events.push_back(batch[k]);
            end
         end
         CMD_RAISE, CMD_CLEAR: begin
            glim = (group_limit < NUM_GROUPS) ? group_limit : NUM_GROUPS;
            ilim = (inst_limit < INSTANCES_PER_GROUP) ? inst_limit : INSTANCES_PER_GROUP;
            if (item.group >= glim || item.instance_req >= ilim) begin
               expected_events.push_back(report(EV_NONE, ST_RANGE, item.group,
                                                item.instance_req, 1'b1));
            end else begin
               slot = item.group * INSTANCES_PER_GROUP + item.instance_req;
               if (item.command == CMD_RAISE && !armed[slot]) begin
                  d = delay_reg[item.group % DELAY_REGS];
                  if (d == '0) begin
                     d = DELAY_WIDTH'(1);
                  end
                  countdown[slot] = d;
                  armed[slot]     = 1'b1;
                  armed_total     = armed_total + 1'b1;
                  expected_events.push_back(report(EV_RAISED, ST_OK, item.group,
                                                   item.instance_req, 1'b1));
               end else if (item.command == CMD_CLEAR && armed[slot]) begin
                  armed[slot] = 1'b0;
                  armed_total = armed_total - 1'b1;
                  expected_events.push_back(report(EV_CLEARED, ST_OK, item.group,
                                                   item.instance_req, 1'b1));
               end else begin
                  expected_events.push_back(report(EV_NONE, ST_OK, item.group,
                                                   item.instance_req, 1'b1));
               end
            end
         end
         default: begin
            expected_events.push_back(report(EV_NONE, ST_OK, '0, '0, 1'b1));
         end
      endcase
   endtask

   task automatic check_field(input string name, input logic [7:0] exp_val,
                              input logic [7:0] act_val);
      if (act_val !== exp_val) begin
         $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, exp_val, act_val);
         failures++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < DELAY_REGS; k++) begin
            delay_reg[k] = DELAY_RESET;
         end
         for (int s = 0; s < SLOT_COUNT; s++) begin
            countdown[s] = '0;
         end
         group_limit = LIMIT_RESET;
         inst_limit  = LIMIT_RESET;
         armed       = '0;
         armed_total = '0;
         expected_events.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            results_seen++;
            if (expected_events.size() == 0) begin
               $display("%0t: result with none expected, actual data %h last %b", $time,
                        rsp_tdata, rsp_tlast);
               failures++;
            end else begin
               want = expected_events.pop_front();
               got  = rsp_tdata;
               if (got.event_res == EV_EXPIRED) begin
                  expiries_seen++;
               end
               check_field("event_res", want.ev, got.event_res);
               check_field("status", want.st, got.status);
               check_field("slot_group", want.grp, got.slot_group);
               check_field("slot_instance", want.inst, got.slot_instance);
               check_field("armed_count", want.count, got.armed_count);
               check_field("fill", '0, got.fill);
               check_field("last", want.last, rsp_tlast);
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_DELAY0:    delay_reg[0] = csr_data;
               REG_DELAY1:    delay_reg[1] = csr_data;
               REG_DELAY2:    delay_reg[2] = csr_data;
               REG_DELAY3:    delay_reg[3] = csr_data;
               REG_GROUPS:    group_limit  = csr_data[LIMREG_W-1:0];
               REG_INSTANCES: inst_limit   = csr_data[LIMREG_W-1:0];
               default:       ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            apply_fault_command(req_tdata);
         end
      end
      pending <= expected_events.size();
   end

endmodule

FILE: verif/tb.sv
// Testbench top for the grouped fault timeout monitor: drives directed and random items and
// register writes with random idling, and gives the verdict from the checker's failure count.
// Depends on gftm_pkg, grouped_fault_timeout_monitor and gftm_checker.
module tb;
   import gftm_pkg::*;

   localparam logic [CMD_W-1:0]     CMD_UNUSED   = 2'd3;
   localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
   localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;
   logic                  csr_valid  = 1'b0;
   logic                  csr_ready;
   logic [CFG_IDX_W-1:0]  csr_index  = '0;
   logic [CFG_DATA_W-1:0] csr_data   = '0;

   int   failures;
   int   pending;
   int   results_seen;
   int   expiries_seen;
   int   items_sent    = 0;
   int   settings_used = 0;
   int   cur_groups    = 4;
   int   cur_insts     = 4;
   logic steady        = 1'b0;

   grouped_fault_timeout_monitor u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   gftm_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tlast     (rsp_tlast),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .failures      (failures),
      .pending       (pending),
      .results_seen  (results_seen),
      .expiries_seen (expiries_seen)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_tready <= steady || ($urandom_range(0, 99) >= 16);
   end

   task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [GRP_W-1:0] g,
                            input logic [INST_W-1:0] i);
      while (!steady && $urandom_range(0, 99) < 16) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tdata  <= {i, g, cmd};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      items_sent++;
   endtask

   task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                            input logic [CFG_DATA_W-1:0] value);
      csr_index <= idx;
      csr_data  <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic load_settings(input logic [CFG_DATA_W-1:0] d0, input logic [CFG_DATA_W-1:0] d1,
                                input logic [CFG_DATA_W-1:0] d2, input logic [CFG_DATA_W-1:0] d3,
                                input logic [LIMREG_W-1:0] groups,
                                input logic [LIMREG_W-1:0] insts);
      write_reg(REG_DELAY0, d0);
      write_reg(REG_DELAY1, d1);
      write_reg(REG_DELAY2, d2);
      write_reg(REG_DELAY3, d3);
      write_reg(REG_GROUPS, {13'($urandom), groups});
      write_reg(REG_INSTANCES, {13'($urandom), insts});
      write_reg(REG_SPARE_LO, 16'($urandom));
      write_reg(REG_SPARE_HI, 16'($urandom));
      csr_valid  <= 1'b0;
      cur_groups = (groups < NUM_GROUPS) ? groups : NUM_GROUPS;
      cur_insts  = (insts < INSTANCES_PER_GROUP) ? insts : INSTANCES_PER_GROUP;
      settings_used++;
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (24) @(posedge clock);
   endtask

   task automatic run_mixed(input int count);
      int sent;
      int pick;
      sent = 0;
      while (sent < count) begin
         pick = $urandom_range(0, 99);
         if (cur_groups == 0 || cur_insts == 0) begin
            pick = (pick < 50) ? 20 : 99;
         end
         if (pick < 4) begin
            for (int g = 0; g < cur_groups; g++) begin
               for (int i = 0; i < cur_insts; i++) begin
                  send_item(CMD_RAISE, GRP_W'(g), INST_W'(i));
               end
            end
            sent += cur_groups * cur_insts;
         end else begin
            if (pick < 40) begin
               send_item(CMD_TICK, GRP_W'($urandom_range(0, 7)),
                         INST_W'($urandom_range(0, 7)));
            end else if (pick < 70) begin
               send_item(CMD_RAISE, GRP_W'($urandom_range(0, cur_groups - 1)),
                         INST_W'($urandom_range(0, cur_insts - 1)));
            end else if (pick < 85) begin
               send_item(CMD_CLEAR, GRP_W'($urandom_range(0, cur_groups - 1)),
                         INST_W'($urandom_range(0, cur_insts - 1)));
            end else begin
               send_item(CMD_W'($urandom_range(0, 3)), GRP_W'($urandom_range(0, 7)),
                         INST_W'($urandom_range(0, 7)));
            end
            sent++;
         end
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      load_settings(16'd1, 16'd0, 16'd3, 16'hFFFF, 3'd4, 3'd4);
      send_item(CMD_TICK, 3'd0, 3'd0);
      send_item(CMD_RAISE, 3'd0, 3'd0);
      send_item(CMD_RAISE, 3'd1, 3'd3);
      send_item(CMD_RAISE, 3'd2, 3'd1);
      send_item(CMD_RAISE, 3'd3, 3'd3);
      send_item(CMD_RAISE, 3'd0, 3'd0);
      send_item(CMD_CLEAR, 3'd2, 3'd2);
      send_item(CMD_RAISE, 3'd4, 3'd0);
      send_item(CMD_CLEAR, 3'd0, 3'd4);
      send_item(CMD_RAISE, 3'd7, 3'd7);
      send_item(CMD_CLEAR, 3'd3, 3'd5);
      send_item(CMD_UNUSED, 3'd7, 3'd7);
      send_item(CMD_TICK, 3'd5, 3'd6);
      send_item(CMD_TICK, 3'd7, 3'd7);
      send_item(CMD_TICK, 3'd0, 3'd0);
      send_item(CMD_CLEAR, 3'd3, 3'd3);
      send_item(CMD_CLEAR, 3'd3, 3'd3);

      for (int phase = 0; phase < 7; phase++) begin
         wait_idle();
         steady = (phase == 2);
         case (phase)
            0: load_settings(16'd1, 16'd1, 16'd1, 16'd1, 3'd4, 3'd4);
            1: load_settings(CFG_DATA_W'($urandom_range(1, 5)), CFG_DATA_W'($urandom_range(1, 5)),
                             CFG_DATA_W'($urandom_range(1, 5)), CFG_DATA_W'($urandom_range(1, 5)),
                             LIMREG_W'($urandom_range(1, 4)), LIMREG_W'($urandom_range(1, 4)));
            2: load_settings(CFG_DATA_W'($urandom_range(1, 8)), CFG_DATA_W'($urandom_range(1, 8)),
                             CFG_DATA_W'($urandom_range(1, 8)), CFG_DATA_W'($urandom_range(1, 8)),
                             3'd4, 3'd4);
            3: load_settings(16'hFFFF, 16'd2, 16'hFFFF, 16'd1, 3'd7, 3'd7);
            4: load_settings(16'($urandom), 16'd3, 16'($urandom), 16'd2, 3'd0,
                             LIMREG_W'($urandom_range(0, 7)));
            5: load_settings(DELAY_RESET, DELAY_RESET, DELAY_RESET, DELAY_RESET, 3'd2, 3'd3);
            default: load_settings(CFG_DATA_W'($urandom_range(0, 3)),
                                   CFG_DATA_W'($urandom_range(0, 3)),
                                   CFG_DATA_W'($urandom_range(0, 3)),
                                   CFG_DATA_W'($urandom_range(0, 3)),
                                   LIMREG_W'($urandom_range(1, 7)),
                                   LIMREG_W'($urandom_range(1, 7)));
         endcase
         run_mixed(56);
      end
      steady = 1'b0;
      wait_idle();

      $display("Covered %0d items under %0d register settings; %0d results checked, %0d expiries.",
               items_sent, settings_used, results_seen, expiries_seen);
      if (failures == 0) begin
         $display("** grouped_fault_timeout_monitor: PASSED **");
      end else begin
         $display("** grouped_fault_timeout_monitor: FAILED **");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("Run timed out with %0d results still expected.", pending);
      $display("** grouped_fault_timeout_monitor: FAILED **");
      $finish;
   end

endmodule
